/* rtl/hse_pkg.sv */
// hse_pkg: shared types, constants and functions of the hmac-sha256 engine
// no dependencies; used by hse_datapath, hse_ctrl and hmac_sha256_engine_unit
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

	localparam logic [7:0] PAD_NONE  = 8'h00;
	localparam logic [7:0] PAD_INNER = 8'h36;
	localparam logic [7:0] PAD_OUTER = 8'h5C;
	localparam logic [6:0] BLOCK_BYTES  = 7'd64;
	localparam logic [6:0] DIGEST_BYTES = 7'd32;

	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		SRC_ITEM  = 3'd0,
		SRC_KEY   = 3'd1,
		SRC_PAD80 = 3'd2,
		SRC_ZERO  = 3'd3,
		SRC_LEN   = 3'd4,
		SRC_HDIG  = 3'd5,
		SRC_SDIG  = 3'd6
	} byte_src_t;

	typedef struct packed {
		logic       load_item;
		logic       absorb;
		logic       key_wr;
		logic [5:0] key_addr;
		byte_src_t  src;
		logic [5:0] idx;
		logic [7:0] pad;
		logic       key_ok;
		logic       hash_init;
		logic       latch_bits;
		logic       round;
		logic [5:0] rnd;
		logic       add_h;
		logic       save_dig;
	} hse_cmd_t;

	typedef struct packed {
		logic blk_end;
		logic at56;
	} hse_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input logic [5:0] n);
		rotr = (x >> n) | (x << (6'd32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 6'd2) ^ rotr(x, 6'd13) ^ rotr(x, 6'd22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6'd6) ^ rotr(x, 6'd11) ^ rotr(x, 6'd25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		small_s0 = rotr(x, 6'd7) ^ rotr(x, 6'd18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		small_s1 = rotr(x, 6'd17) ^ rotr(x, 6'd19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		case (t)
			6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage

`default_nettype wire

/* rtl/hse_item_if.sv */
// hse_item_if: input channel of the hmac-sha256 engine, one key or message beat
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface hse_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] data_bytes;
	logic [3:0]  byte_count;
	logic        last_of_part;

	modport source (output valid, kind, data_bytes, byte_count, last_of_part, input ready);
	modport sink (input valid, kind, data_bytes, byte_count, last_of_part, output ready);
endinterface

`default_nettype wire

/* rtl/hse_result_if.sv */
// hse_result_if: output channel of the hmac-sha256 engine, one digest word per beat
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface hse_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

/* rtl/hse_datapath.sv */
// hse_datapath: byte mux, block/schedule words, round unit, hash state, key memory
// depends on hse_pkg; driven by hse_ctrl through hse_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module hse_datapath import hse_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire hse_cmd_t    cmd,
	output hse_stat_t        stat,
	input  wire logic [63:0] data_bytes,
	input  wire logic [1:0]  out_idx,
	output logic [63:0]      digest_word
);

	logic [31:0] h_q [8];
	logic [63:0] len_q;
	logic [31:0] work_q [8];
	logic [31:0] sched_q [16];
	logic [63:0] data_q;
	logic [63:0] bits_q;
	logic [255:0] dig_q;
	logic [7:0]  key_mem [64];
	logic [7:0]  key_rd_q;

	logic [7:0]  byte_v;
	logic [31:0] t1, t2, w_new;
	logic [5:0]  item_sh;
	logic [4:0]  h_sh;
	logic [7:0]  dig_sh;
	logic [4:0]  lane_sh;

	assign item_sh = {~cmd.idx[2:0], 3'b000};
	assign h_sh    = {~cmd.idx[1:0], 3'b000};
	assign dig_sh  = {~cmd.idx[4:0], 3'b000};
	assign lane_sh = {~len_q[1:0], 3'b000};

	always_comb begin
		case (cmd.src)
			SRC_ITEM:  byte_v = data_q[item_sh +: 8];
			SRC_KEY:   byte_v = cmd.key_ok ? (key_rd_q ^ cmd.pad) : cmd.pad;
			SRC_PAD80: byte_v = 8'h80;
			SRC_ZERO:  byte_v = 8'h00;
			SRC_LEN:   byte_v = bits_q[item_sh +: 8];
			SRC_HDIG:  byte_v = h_q[cmd.idx[4:2]][h_sh +: 8];
			SRC_SDIG:  byte_v = dig_q[dig_sh +: 8];
			default:   byte_v = 8'h00;
		endcase
	end

	always_comb begin
		t1 = work_q[7] + big_s1(work_q[4]) + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ round_k(cmd.rnd) + sched_q[0];
		t2 = big_s0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
		w_new = small_s1(sched_q[14]) + sched_q[9] + small_s0(sched_q[1]) + sched_q[0];
	end

	assign stat.blk_end = (len_q[5:0] == 6'd63);
	assign stat.at56    = (len_q[5:0] == 6'd56);
	assign digest_word  = {h_q[{out_idx, 1'b0}], h_q[{out_idx, 1'b1}]};

	// hash state and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= SHA_IV[32*(7-i) +: 32];
			len_q <= '0;
		end else begin
			if (cmd.hash_init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= SHA_IV[32*(7-i) +: 32];
				len_q <= '0;
			end else begin
				if (cmd.add_h) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + work_q[i];
				end
				if (cmd.absorb) len_q <= len_q + 64'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) data_q <= data_bytes;
		if (cmd.latch_bits) bits_q <= {len_q[60:0], 3'b000};
		if (cmd.save_dig) dig_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
		if (cmd.absorb) begin
			sched_q[len_q[5:2]][lane_sh +: 8] <= byte_v;
			if (len_q[5:0] == 6'd63) begin
				for (int i = 0; i < 8; i++) work_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
			sched_q[15] <= w_new;
		end
	end

	// key memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.key_wr) key_mem[cmd.key_addr] <= byte_v;
		key_rd_q <= key_mem[cmd.key_addr];
	end

endmodule

`default_nettype wire

/* rtl/hse_ctrl.sv */
// hse_ctrl: sequencer of the hmac-sha256 engine (key load, padding, rounds, output)
// depends on hse_pkg; commands hse_datapath through hse_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module hse_ctrl import hse_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       in_kind,
	input  wire logic [3:0] in_count,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      out_idx,
	output logic            out_last,
	output hse_cmd_t        cmd,
	input  wire hse_stat_t  stat
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_ITEM  = 10'b0000000010,
		S_KPAD  = 10'b0000000100,
		S_COMP  = 10'b0000001000,
		S_ADDH  = 10'b0000010000,
		S_FIN   = 10'b0000100000,
		S_FDONE = 10'b0001000000,
		S_KSAVE = 10'b0010000000,
		S_DABS  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		JOB_KEYHASH = 2'd0,
		JOB_INNER   = 2'd1,
		JOB_OUTER   = 2'd2
	} job_t;

	state_t     state_q, state_d, ret_q, ret_d;
	job_t       job_q, job_d;
	logic       phase_msg_q, phase_msg_d;
	logic       hashed_q, hashed_d;
	logic [6:0] key_len_q, key_len_d;
	logic       kind_q, kind_d;
	logic [3:0] cnt_q, cnt_d;
	logic       last_q, last_d;
	logic [3:0] bi_q, bi_d;
	logic [6:0] k_q, k_d;
	logic [5:0] rnd_q, rnd_d;
	logic       fin_started_q, fin_started_d;
	logic       lstage_q, lstage_d;
	logic [2:0] lcnt_q, lcnt_d;
	logic [1:0] oidx_q, oidx_d;
	logic [6:0] km1;

	assign km1      = k_q - 7'd1;
	assign out_idx  = oidx_q;
	assign out_last = (oidx_q == 2'd3);

	always_comb begin
		cmd           = '0;
		cmd.src       = SRC_ZERO;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		state_d       = state_q;
		ret_d         = ret_q;
		job_d         = job_q;
		phase_msg_d   = phase_msg_q;
		hashed_d      = hashed_q;
		key_len_d     = key_len_q;
		kind_d        = kind_q;
		cnt_d         = cnt_q;
		last_d        = last_q;
		bi_d          = bi_q;
		k_d           = k_q;
		rnd_d         = rnd_q;
		fin_started_d = fin_started_q;
		lstage_d      = lstage_q;
		lcnt_d        = lcnt_q;
		oidx_d        = oidx_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					kind_d = in_kind;
					cnt_d  = (in_count > 4'd8) ? 4'd8 : in_count;
					last_d = in_last;
					bi_d   = '0;
					if (in_kind == phase_msg_q) state_d = S_ITEM;
				end
			end
			S_ITEM: begin
				if (bi_q == cnt_q) begin
					if (!last_q) begin
						state_d = S_IDLE;
					end else if (!kind_q && !hashed_q) begin
						cmd.hash_init = 1'b1;
						job_d   = JOB_INNER;
						k_d     = '0;
						state_d = S_KPAD;
					end else begin
						job_d         = kind_q ? JOB_INNER : JOB_KEYHASH;
						fin_started_d = 1'b0;
						lstage_d      = 1'b0;
						lcnt_d        = '0;
						state_d       = S_FIN;
					end
				end else begin
					cmd.src = SRC_ITEM;
					cmd.idx = {3'b000, bi_q[2:0]};
					if (!kind_q && !hashed_q && (key_len_q < BLOCK_BYTES)) begin
						cmd.key_wr   = 1'b1;
						cmd.key_addr = key_len_q[5:0];
						key_len_d    = key_len_q + 7'd1;
						bi_d         = bi_q + 4'd1;
					end else if (!kind_q && !hashed_q) begin
						// key grew past one block: hash it from here on
						hashed_d      = 1'b1;
						cmd.hash_init = 1'b1;
						job_d         = JOB_KEYHASH;
						k_d           = '0;
						state_d       = S_KPAD;
					end else begin
						cmd.absorb = 1'b1;
						bi_d       = bi_q + 4'd1;
						if (stat.blk_end) begin
							rnd_d   = '0;
							ret_d   = S_ITEM;
							state_d = S_COMP;
						end
					end
				end
			end
			S_KPAD: begin
				cmd.key_addr = k_q[5:0];
				k_d          = k_q + 7'd1;
				case (job_q)
					JOB_INNER: cmd.pad = PAD_INNER;
					JOB_OUTER: cmd.pad = PAD_OUTER;
					default:   cmd.pad = PAD_NONE;
				endcase
				if (k_q != 7'd0) begin
					cmd.absorb = 1'b1;
					cmd.src    = SRC_KEY;
					cmd.idx    = km1[5:0];
					cmd.key_ok = (km1 < key_len_q);
				end
				if (k_q == BLOCK_BYTES) begin
					rnd_d   = '0;
					k_d     = '0;
					state_d = S_COMP;
					case (job_q)
						JOB_INNER: begin
							ret_d       = S_IDLE;
							phase_msg_d = 1'b1;
						end
						JOB_OUTER: ret_d = S_DABS;
						default:   ret_d = S_ITEM;
					endcase
				end
			end
			S_COMP: begin
				cmd.round = 1'b1;
				cmd.rnd   = rnd_q;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == 6'd63) state_d = S_ADDH;
			end
			S_ADDH: begin
				cmd.add_h = 1'b1;
				state_d   = ret_q;
			end
			S_FIN: begin
				cmd.absorb = 1'b1;
				ret_d      = S_FIN;
				if (!fin_started_q) begin
					cmd.src        = SRC_PAD80;
					cmd.latch_bits = 1'b1;
					fin_started_d  = 1'b1;
				end else if (!lstage_q && !stat.at56) begin
					cmd.src = SRC_ZERO;
				end else begin
					cmd.src  = SRC_LEN;
					cmd.idx  = {3'b000, lcnt_q};
					lstage_d = 1'b1;
					lcnt_d   = lcnt_q + 3'd1;
					if (lcnt_q == 3'd7) ret_d = S_FDONE;
				end
				if (stat.blk_end) begin
					rnd_d   = '0;
					state_d = S_COMP;
				end
			end
			S_FDONE: begin
				k_d = '0;
				case (job_q)
					JOB_KEYHASH: state_d = S_KSAVE;
					JOB_INNER: begin
						cmd.save_dig  = 1'b1;
						cmd.hash_init = 1'b1;
						job_d         = JOB_OUTER;
						state_d       = S_KPAD;
					end
					default: begin
						oidx_d  = '0;
						state_d = S_OUT;
					end
				endcase
			end
			S_KSAVE: begin
				cmd.src      = SRC_HDIG;
				cmd.idx      = {1'b0, k_q[4:0]};
				cmd.key_wr   = 1'b1;
				cmd.key_addr = k_q[5:0];
				k_d          = k_q + 7'd1;
				if (k_q == DIGEST_BYTES - 7'd1) begin
					key_len_d     = DIGEST_BYTES;
					cmd.hash_init = 1'b1;
					job_d         = JOB_INNER;
					k_d           = '0;
					state_d       = S_KPAD;
				end
			end
			S_DABS: begin
				cmd.absorb = 1'b1;
				cmd.src    = SRC_SDIG;
				cmd.idx    = {1'b0, k_q[4:0]};
				k_d        = k_q + 7'd1;
				if (k_q == DIGEST_BYTES - 7'd1) begin
					fin_started_d = 1'b0;
					lstage_d      = 1'b0;
					lcnt_d        = '0;
					state_d       = S_FIN;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					oidx_d = oidx_q + 2'd1;
					if (oidx_q == 2'd3) begin
						cmd.hash_init = 1'b1;
						key_len_d     = '0;
						hashed_d      = 1'b0;
						phase_msg_d   = 1'b0;
						state_d       = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			job_q         <= JOB_KEYHASH;
			phase_msg_q   <= 1'b0;
			hashed_q      <= 1'b0;
			key_len_q     <= '0;
			kind_q        <= 1'b0;
			cnt_q         <= '0;
			last_q        <= 1'b0;
			bi_q          <= '0;
			k_q           <= '0;
			rnd_q         <= '0;
			fin_started_q <= 1'b0;
			lstage_q      <= 1'b0;
			lcnt_q        <= '0;
			oidx_q        <= '0;
		end else begin
			state_q       <= state_d;
			ret_q         <= ret_d;
			job_q         <= job_d;
			phase_msg_q   <= phase_msg_d;
			hashed_q      <= hashed_d;
			key_len_q     <= key_len_d;
			kind_q        <= kind_d;
			cnt_q         <= cnt_d;
			last_q        <= last_d;
			bi_q          <= bi_d;
			k_q           <= k_d;
			rnd_q         <= rnd_d;
			fin_started_q <= fin_started_d;
			lstage_q      <= lstage_d;
			lcnt_q        <= lcnt_d;
			oidx_q        <= oidx_d;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output open together");

	a_key_len: assert property (@(posedge clk) disable iff (!arst_n)
		key_len_q <= BLOCK_BYTES) else $error("key fill count past one block");

	a_comp_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP && $past(state_q) != S_COMP) |-> rnd_q == 6'd0)
		else $error("compression entered mid-round");

	a_done_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && oidx_q == 2'd3) |=> (state_q == S_IDLE && !phase_msg_q))
		else $error("engine not back to key phase after digest");

endmodule

`default_nettype wire

/* rtl/hmac_sha256_engine_unit.sv */
// hmac_sha256_engine_unit: top level of the hmac-sha256 engine
// depends on hse_pkg, hse_item_if, hse_result_if, hse_ctrl, hse_datapath
//
//   port    dir  beat
//   item    in   kind, data_bytes (up to 8 bytes, msb first), byte_count, last_of_part
//   result  out  digest_word, word_index, last_word (four beats per message)
//
// one item is taken in idle; its key or message bytes are then taken in one at a time
// every filled 64-byte block then runs 64 rounds on one round unit, then one add
// the tail of a message adds 3 to 4 blocks
// reset returns to awaiting key; no clearing pass, the key memory uses a fill count
// result beats wait on ready; no item is taken until the last beat is gone
`timescale 1ns / 1ps
`default_nettype none

module hmac_sha256_engine_unit import hse_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	hse_item_if.sink     item,
	hse_result_if.source result
);

	hse_cmd_t  cmd;
	hse_stat_t stat;

	hse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_kind   (item.kind),
		.in_count  (item.byte_count),
		.in_last   (item.last_of_part),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_idx   (result.word_index),
		.out_last  (result.last_word),
		.cmd       (cmd),
		.stat      (stat)
	);

	hse_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.data_bytes  (item.data_bytes),
		.out_idx     (result.word_index),
		.digest_word (result.digest_word)
	);

endmodule

`default_nettype wire
